// ===== src/quaternion_to_scaled_rotation_assert.svh =====
// Assertion macros for the quaternion to scaled rotation block.
// Used by the top level only; they vanish when SYNTHESIS is defined.
`ifndef QUATERNION_TO_SCALED_ROTATION_ASSERT_SVH
`define QUATERNION_TO_SCALED_ROTATION_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define Q2R_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("q2r assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define Q2R_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("q2r assertion failed");
`else
`define Q2R_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define Q2R_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== src/q2r_pkg.sv =====
// Package for the quaternion to scaled rotation block: request types,
// the buses that run along the cell chains, constants and rounding helpers.
// Depends on nothing.
package q2r_pkg;

    localparam int unsigned SQ_STEPS  = 32;
    localparam int unsigned DIV_STEPS = 31;
    localparam int unsigned LANES     = 3;

    localparam logic [63:0] ONE_Q60   = 64'h1000_0000_0000_0000;
    localparam logic [63:0] SMALL_Q60 = 64'h0000_001A_C000_0000;
    localparam logic signed [31:0] ONE_Q16  = 32'sh0001_0000;
    localparam logic signed [32:0] CLAMP_HI = 33'sh0_8000_0000;
    localparam logic signed [32:0] CLAMP_LO = 33'sh1_8000_0000;
    localparam logic [30:0] QUO_MAX = 31'h4000_0000;

    typedef struct packed {
        logic signed [31:0] quat_b;
        logic signed [31:0] quat_c;
        logic signed [31:0] quat_d;
        logic signed [31:0] spacing_x;
        logic signed [31:0] spacing_y;
        logic signed [31:0] spacing_z;
        logic               left_handed;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
        logic signed [31:0] t0;
        logic signed [31:0] t1;
        logic signed [31:0] t2;
    } t_out_rsp;

    // Data that rides along with a request through the chains.
    typedef struct packed {
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic               norm;
        logic signed [31:0] xs;
        logic signed [31:0] ys;
        logic signed [31:0] zs;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
    } t_side;

    // Control of one chain cell: the enable shared by every cell, and its own valid.
    typedef struct packed {
        logic en;
        logic valid;
    } t_cell_ctl;

    // Square root chain: partial remainder, partial root, operand bits left.
    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] opnd;
        t_side       side;
    } t_sq_bus;

    // Division chain: three lanes sharing one divisor (the root).
    typedef struct packed {
        logic [LANES-1:0][32:0] rem;
        logic [LANES-1:0][30:0] num;
        logic [LANES-1:0][30:0] quo;
        logic [31:0]            root;
        t_side                  side;
    } t_dv_bus;

    // Arithmetic shift right by 30, rounding to nearest, ties away from zero.
    function automatic logic signed [63:0] rshr30(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] rnd;
        mag = v[63] ? (64'd0 - v) : v;
        rnd = (mag + 64'h0000_0000_2000_0000) >> 30;
        return v[63] ? -$signed(rnd) : $signed(rnd);
    endfunction

    // Clamp to plus or minus 2^31.
    function automatic logic signed [32:0] clamp33(input logic signed [63:0] v);
        logic signed [32:0] r;
        if (v > 64'(CLAMP_HI)) begin
            r = CLAMP_HI;
        end else if (v < 64'(CLAMP_LO)) begin
            r = CLAMP_LO;
        end else begin
            r = v[32:0];
        end
        return r;
    endfunction

    // Saturate to the int32 range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // A spacing that is not positive reads as 1.0.
    function automatic logic signed [31:0] fix_spacing(input logic signed [31:0] v);
        return (v > 32'sd0) ? v : ONE_Q16;
    endfunction

endpackage

// ===== src/q2r_if.sv =====
// Request channels of the quaternion to scaled rotation block.
// Depends on q2r_pkg for the payload types.
interface q2r_req_if import q2r_pkg::*; ();
    logic    valid;
    logic    ready;
    t_in_req req;
    modport source (output valid, output req, input ready);
    modport sink (input valid, input req, output ready);
endinterface

interface q2r_rsp_if import q2r_pkg::*; ();
    logic     valid;
    logic     ready;
    t_out_rsp rsp;
    modport source (output valid, output rsp, input ready);
    modport sink (input valid, input rsp, output ready);
endinterface

// ===== src/q2r_sqrt_cell.sv =====
// One cell of the integer square root chain: resolves one root bit.
// Depends on q2r_pkg.
module q2r_sqrt_cell import q2r_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_sq_bus   i_bus,
    output logic      o_valid,
    output t_sq_bus   o_bus
);

    logic [33:0] w_rem2;
    logic [33:0] w_trial;
    t_sq_bus     n_bus;
    t_sq_bus     r_bus;
    logic        r_valid;

    // Bring down two operand bits and try the next root bit.
    always_comb begin
        w_rem2     = {i_bus.rem[31:0], i_bus.opnd[63:62]};
        w_trial    = {i_bus.root, 2'b01};
        n_bus      = i_bus;
        n_bus.opnd = {i_bus.opnd[61:0], 2'b00};
        if (w_rem2 >= w_trial) begin
            n_bus.rem  = w_rem2 - w_trial;
            n_bus.root = {i_bus.root[30:0], 1'b1};
        end else begin
            n_bus.rem  = w_rem2;
            n_bus.root = {i_bus.root[30:0], 1'b0};
        end
    end

    // Valid bit is reset; the data register is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_bus <= n_bus;
        end
    end

    assign o_valid = r_valid;
    assign o_bus   = r_bus;

endmodule

// ===== src/q2r_div_cell.sv =====
// One cell of the restoring division chain: one quotient bit for each of
// three lanes that share a divisor. Depends on q2r_pkg.
module q2r_div_cell import q2r_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_dv_bus   i_bus,
    output logic      o_valid,
    output t_dv_bus   o_bus
);

    logic [LANES-1:0][32:0] w_rem2;
    t_dv_bus                n_bus;
    t_dv_bus                r_bus;
    logic                   r_valid;

    // Shift in the next numerator bit and subtract the divisor if it fits.
    always_comb begin
        n_bus = i_bus;
        for (int k = 0; k < LANES; k++) begin
            w_rem2[k] = {i_bus.rem[k][31:0], i_bus.num[k][30]};
            if (w_rem2[k] >= {1'b0, i_bus.root}) begin
                n_bus.rem[k] = w_rem2[k] - {1'b0, i_bus.root};
                n_bus.quo[k] = {i_bus.quo[k][29:0], 1'b1};
            end else begin
                n_bus.rem[k] = w_rem2[k];
                n_bus.quo[k] = {i_bus.quo[k][29:0], 1'b0};
            end
            n_bus.num[k] = {i_bus.num[k][29:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_bus <= n_bus;
        end
    end

    assign o_valid = r_valid;
    assign o_bus   = r_bus;

endmodule

// ===== src/quaternion_to_scaled_rotation.sv =====
// Quaternion to scaled rotation matrix. Depends on q2r_pkg, q2r_if and the cells.
// A request passes through 72 register stages, the last being the output register;
// throughput one request per cycle when not stalled. Depth is set by the
// 32-cell square root chain and the 31-cell division chain. The pipeline stalls
// only when the output register and the last stage are both full.
// Synchronous active-low reset clears valids.
`include "quaternion_to_scaled_rotation_assert.svh"

module quaternion_to_scaled_rotation import q2r_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    q2r_req_if.sink   i_req,
    q2r_rsp_if.source o_rsp
);

    logic      w_en;
    logic      w_out_load;
    t_cell_ctl w_ctl_sq [SQ_STEPS];
    t_cell_ctl w_ctl_dv [DIV_STEPS];

    // Stage 1: squares and spacing fix-up.
    logic               r_s1_v;
    logic signed [63:0] r_s1_bb, r_s1_cc, r_s1_dd;
    t_side              r_s1_side;

    // Stage 2 and the square root chain.
    logic [63:0] w_sq_sum;
    logic        w_norm;
    t_side       w_s2_side;
    t_sq_bus     w_sq   [SQ_STEPS+1];
    logic        w_sq_v [SQ_STEPS+1];
    logic        r_s2_v;
    t_sq_bus     r_s2_bus;

    // Division setup and chain.
    logic [LANES-1:0][31:0] w_mag;
    logic [LANES-1:0][61:0] w_num;
    t_dv_bus                n_p_bus;
    logic                   r_p_v;
    t_dv_bus                r_p_bus;
    t_dv_bus                w_dv   [DIV_STEPS+1];
    logic                   w_dv_v [DIV_STEPS+1];

    // Final quaternion and matrix stages.
    t_side              w_dv_side;
    logic               r_f_v;
    logic signed [31:0] r_f_a, r_f_b, r_f_c, r_f_d;
    t_side              r_f_side;
    logic               r_m1_v;
    logic signed [63:0] r_aa, r_bb, r_cc, r_dd, r_ab, r_ac, r_ad, r_bc, r_bd, r_cd;
    t_side              r_m1_side;
    logic               r_m2_v;
    logic signed [63:0] r_m2_e [3][3];
    t_side              r_m2_side;
    logic               r_m3_v;
    logic signed [32:0] r_m3_r [3][3];
    t_side              r_m3_side;
    logic signed [31:0] w_col_sp [3];
    logic               r_m4_v;
    logic signed [63:0] r_m4_p [3][3];
    t_side              r_m4_side;
    logic signed [31:0] w_out_m [3][3];
    logic               r_out_v;
    t_out_rsp           r_out;

    // Flow control: hold everything only when the output waits and the
    // last stage has a result behind it.
    assign w_out_load  = !r_out_v || o_rsp.ready;
    assign w_en        = w_out_load || !r_m4_v;
    assign i_req.ready = w_en;

    // Stage 1 registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_bb        <= i_req.req.quat_b * i_req.req.quat_b;
            r_s1_cc        <= i_req.req.quat_c * i_req.req.quat_c;
            r_s1_dd        <= i_req.req.quat_d * i_req.req.quat_d;
            r_s1_side.b    <= i_req.req.quat_b;
            r_s1_side.c    <= i_req.req.quat_c;
            r_s1_side.d    <= i_req.req.quat_d;
            r_s1_side.norm <= 1'b0;
            r_s1_side.xs   <= fix_spacing(i_req.req.spacing_x);
            r_s1_side.ys   <= fix_spacing(i_req.req.spacing_y);
            r_s1_side.zs   <= i_req.req.left_handed ? -fix_spacing(i_req.req.spacing_z)
                                                    : fix_spacing(i_req.req.spacing_z);
            r_s1_side.tx   <= i_req.req.shift_x;
            r_s1_side.ty   <= i_req.req.shift_y;
            r_s1_side.tz   <= i_req.req.shift_z;
        end
    end

    // Stage 2: squared length, path choice and square root operand.
    always_comb begin
        w_sq_sum       = r_s1_bb + r_s1_cc + r_s1_dd;
        w_norm         = (w_sq_sum >= ONE_Q60) || ((ONE_Q60 - w_sq_sum) < SMALL_Q60);
        w_s2_side      = r_s1_side;
        w_s2_side.norm = w_norm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_bus.rem  <= '0;
            r_s2_bus.root <= '0;
            r_s2_bus.opnd <= w_norm ? w_sq_sum : (ONE_Q60 - w_sq_sum);
            r_s2_bus.side <= w_s2_side;
        end
    end

    // Square root chain, one root bit per cell.
    assign w_sq[0]   = r_s2_bus;
    assign w_sq_v[0] = r_s2_v;

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        assign w_ctl_sq[g] = '{en: w_en, valid: w_sq_v[g]};
        q2r_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl_sq[g]),
            .i_bus   (w_sq[g]),
            .o_valid (w_sq_v[g+1]),
            .o_bus   (w_sq[g+1])
        );
    end

    // Division setup: numerator is |x| * 2^30 plus half the root.
    always_comb begin
        w_mag[0] = w_sq[SQ_STEPS].side.b[31] ? (32'd0 - w_sq[SQ_STEPS].side.b)
                                             : w_sq[SQ_STEPS].side.b;
        w_mag[1] = w_sq[SQ_STEPS].side.c[31] ? (32'd0 - w_sq[SQ_STEPS].side.c)
                                             : w_sq[SQ_STEPS].side.c;
        w_mag[2] = w_sq[SQ_STEPS].side.d[31] ? (32'd0 - w_sq[SQ_STEPS].side.d)
                                             : w_sq[SQ_STEPS].side.d;
        n_p_bus.root = w_sq[SQ_STEPS].root;
        n_p_bus.side = w_sq[SQ_STEPS].side;
        for (int k = 0; k < LANES; k++) begin
            w_num[k]       = {w_mag[k], 30'd0} + {31'd0, w_sq[SQ_STEPS].root[31:1]};
            n_p_bus.rem[k] = {2'b00, w_num[k][61:31]};
            n_p_bus.num[k] = w_num[k][30:0];
            n_p_bus.quo[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (w_en) begin
            r_p_v <= w_sq_v[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_bus <= n_p_bus;
        end
    end

    // Division chain, one quotient bit per cell.
    assign w_dv[0]   = r_p_bus;
    assign w_dv_v[0] = r_p_v;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        assign w_ctl_dv[g] = '{en: w_en, valid: w_dv_v[g]};
        q2r_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl_dv[g]),
            .i_bus   (w_dv[g]),
            .o_valid (w_dv_v[g+1]),
            .o_bus   (w_dv[g+1])
        );
    end

    assign w_dv_side = w_dv[DIV_STEPS].side;

    // Final quaternion: normalized vector with a zero real part, or the
    // original vector with the computed real part.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (w_en) begin
            r_f_v <= w_dv_v[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_side <= w_dv_side;
            if (w_dv_side.norm) begin
                r_f_a <= '0;
                r_f_b <= w_dv_side.b[31] ? -$signed({1'b0, w_dv[DIV_STEPS].quo[0]})
                                         : $signed({1'b0, w_dv[DIV_STEPS].quo[0]});
                r_f_c <= w_dv_side.c[31] ? -$signed({1'b0, w_dv[DIV_STEPS].quo[1]})
                                         : $signed({1'b0, w_dv[DIV_STEPS].quo[1]});
                r_f_d <= w_dv_side.d[31] ? -$signed({1'b0, w_dv[DIV_STEPS].quo[2]})
                                         : $signed({1'b0, w_dv[DIV_STEPS].quo[2]});
            end else begin
                r_f_a <= $signed({1'b0, w_dv[DIV_STEPS].root[30:0]});
                r_f_b <= w_dv_side.b;
                r_f_c <= w_dv_side.c;
                r_f_d <= w_dv_side.d;
            end
        end
    end

    // Valid bits of the matrix stages and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v  <= 1'b0;
            r_m2_v  <= 1'b0;
            r_m3_v  <= 1'b0;
            r_m4_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_en) begin
                r_m1_v <= r_f_v;
                r_m2_v <= r_m1_v;
                r_m3_v <= r_m2_v;
                r_m4_v <= r_m3_v;
            end
            if (w_out_load) begin
                r_out_v <= r_m4_v;
            end
        end
    end

    assign w_col_sp[0] = r_m3_side.xs;
    assign w_col_sp[1] = r_m3_side.ys;
    assign w_col_sp[2] = r_m3_side.zs;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_out_m[i][j] = sat32(rshr30(r_m4_p[i][j]));
            end
        end
    end

    // Matrix datapath: products, sums, rounding, spacing scale.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_aa      <= r_f_a * r_f_a;
            r_bb      <= r_f_b * r_f_b;
            r_cc      <= r_f_c * r_f_c;
            r_dd      <= r_f_d * r_f_d;
            r_ab      <= r_f_a * r_f_b;
            r_ac      <= r_f_a * r_f_c;
            r_ad      <= r_f_a * r_f_d;
            r_bc      <= r_f_b * r_f_c;
            r_bd      <= r_f_b * r_f_d;
            r_cd      <= r_f_c * r_f_d;
            r_m1_side <= r_f_side;

            r_m2_e[0][0] <= r_aa + r_bb - r_cc - r_dd;
            r_m2_e[0][1] <= (r_bc - r_ad) <<< 1;
            r_m2_e[0][2] <= (r_bd + r_ac) <<< 1;
            r_m2_e[1][0] <= (r_bc + r_ad) <<< 1;
            r_m2_e[1][1] <= r_aa + r_cc - r_bb - r_dd;
            r_m2_e[1][2] <= (r_cd - r_ab) <<< 1;
            r_m2_e[2][0] <= (r_bd - r_ac) <<< 1;
            r_m2_e[2][1] <= (r_cd + r_ab) <<< 1;
            r_m2_e[2][2] <= r_aa + r_dd - r_cc - r_bb;
            r_m2_side    <= r_m1_side;

            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_m3_r[i][j] <= clamp33(rshr30(r_m2_e[i][j]));
                    r_m4_p[i][j] <= 64'(65'(r_m3_r[i][j]) * 65'(w_col_sp[j]));
                end
            end
            r_m3_side <= r_m2_side;
            r_m4_side <= r_m3_side;
        end
    end

    // Output register: round, saturate and copy the offsets.
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.m00 <= w_out_m[0][0];
            r_out.m01 <= w_out_m[0][1];
            r_out.m02 <= w_out_m[0][2];
            r_out.m10 <= w_out_m[1][0];
            r_out.m11 <= w_out_m[1][1];
            r_out.m12 <= w_out_m[1][2];
            r_out.m20 <= w_out_m[2][0];
            r_out.m21 <= w_out_m[2][1];
            r_out.m22 <= w_out_m[2][2];
            r_out.t0  <= r_m4_side.tx;
            r_out.t1  <= r_m4_side.ty;
            r_out.t2  <= r_m4_side.tz;
        end
    end

    assign o_rsp.valid = r_out_v;
    assign o_rsp.rsp   = r_out;

    // The real part on the direct path is at most one.
    `Q2R_ASSERT_NOW(a_root_range, i_clk, i_rst_n, w_sq_v[SQ_STEPS] && !w_sq[SQ_STEPS].side.norm, w_sq[SQ_STEPS].root <= 32'h4000_0000)
    // Normalized components never exceed one.
    `Q2R_ASSERT_NOW(a_quo_range, i_clk, i_rst_n, w_dv_v[DIV_STEPS] && w_dv_side.norm, (w_dv[DIV_STEPS].quo[0] <= QUO_MAX) && (w_dv[DIV_STEPS].quo[1] <= QUO_MAX) && (w_dv[DIV_STEPS].quo[2] <= QUO_MAX))
    // An accepted request enters the first stage.
    `Q2R_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_req.valid && i_req.ready, r_s1_v)

endmodule

// ===== tb/sv/tb_quaternion_to_scaled_rotation.sv =====
// Testbench for the quaternion to scaled rotation block: random and corner
// orientations, an in-bench bit-exact predictor and an in-order scoreboard.
// Depends on q2r_pkg, q2r_if and the block's RTL.
module tb_quaternion_to_scaled_rotation;
    import q2r_pkg::*;

    // Expected rotations and offsets, compared in request order.
    class rotation_scoreboard;
        t_out_rsp pending[$];
        int unsigned mismatches;
        int unsigned checked;

        // Shift right by n with rounding to nearest, ties away from zero.
        function automatic longint round_shift(longint v, int n);
            longint unsigned m;
            m = (v < 0) ? -v : v;
            m = (m + (64'd1 << (n - 1))) >> n;
            return (v < 0) ? -longint'(m) : longint'(m);
        endfunction

        // Integer square root with floor rounding.
        function automatic longint unsigned floor_root(longint unsigned x);
            longint unsigned r;
            longint unsigned lo;
            longint unsigned hi;
            longint unsigned mid;
            lo = 0;
            hi = 64'd4294967295;
            while (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                if (mid * mid <= x) lo = mid;
                else hi = mid - 1;
            end
            r = lo;
            return r;
        endfunction

        // Scale one component back to unit length.
        function automatic longint unit_part(longint x, longint unsigned s);
            longint unsigned m;
            m = (x < 0) ? -x : x;
            m = ((m << 30) + s / 2) / s;
            return (x < 0) ? -longint'(m) : longint'(m);
        endfunction

        // Rotation term times spacing, rounded and saturated to Q16.16.
        function automatic logic signed [31:0] scaled_term(longint r60, longint sp);
            longint r;
            longint p;
            r = round_shift(r60, 30);
            if (r > 64'sd2147483648) r = 64'sd2147483648;
            if (r < -64'sd2147483648) r = -64'sd2147483648;
            p = round_shift(r * sp, 30);
            if (p > 64'sd2147483647) p = 64'sd2147483647;
            if (p < -64'sd2147483648) p = -64'sd2147483648;
            return p[31:0];
        endfunction

        function automatic longint pos_spacing(logic signed [31:0] v);
            return (v > 0) ? longint'(v) : 64'sd65536;
        endfunction

        // Note an accepted request and queue its expected result.
        function void note_request(t_in_req q);
            longint b, c, d, a, xs, ys, zs;
            longint aa, bb, cc, dd, ab, ac, ad, bc, bd, cd;
            longint unsigned sq;
            longint unsigned s;
            t_out_rsp e;
            b = q.quat_b;
            c = q.quat_c;
            d = q.quat_d;
            sq = b * b + c * c + d * d;
            if (sq >= ONE_Q60 || ONE_Q60 - sq < SMALL_Q60) begin
                s = floor_root(sq);
                b = unit_part(b, s);
                c = unit_part(c, s);
                d = unit_part(d, s);
                a = 0;
            end else begin
                a = floor_root(ONE_Q60 - sq);
            end
            xs = pos_spacing(q.spacing_x);
            ys = pos_spacing(q.spacing_y);
            zs = pos_spacing(q.spacing_z);
            if (q.left_handed) zs = -zs;
            aa = a * a; bb = b * b; cc = c * c; dd = d * d;
            ab = a * b; ac = a * c; ad = a * d;
            bc = b * c; bd = b * d; cd = c * d;
            e.m00 = scaled_term(aa + bb - cc - dd, xs);
            e.m01 = scaled_term((bc - ad) * 2, ys);
            e.m02 = scaled_term((bd + ac) * 2, zs);
            e.m10 = scaled_term((bc + ad) * 2, xs);
            e.m11 = scaled_term(aa + cc - bb - dd, ys);
            e.m12 = scaled_term((cd - ab) * 2, zs);
            e.m20 = scaled_term((bd - ac) * 2, xs);
            e.m21 = scaled_term((cd + ab) * 2, ys);
            e.m22 = scaled_term(aa + dd - cc - bb, zs);
            e.t0 = q.shift_x;
            e.t1 = q.shift_y;
            e.t2 = q.shift_z;
            pending.push_back(e);
        endfunction

        function void report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on %s: expected %h, got %h", name, exp_v, act_v);
            end
        endfunction

        // Compare one result with the oldest expectation, field by field.
        function void check_result(t_out_rsp r);
            t_out_rsp e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result arrived with nothing expected");
                return;
            end
            e = pending.pop_front();
            checked++;
            report_field("m00", e.m00, r.m00);
            report_field("m01", e.m01, r.m01);
            report_field("m02", e.m02, r.m02);
            report_field("m10", e.m10, r.m10);
            report_field("m11", e.m11, r.m11);
            report_field("m12", e.m12, r.m12);
            report_field("m20", e.m20, r.m20);
            report_field("m21", e.m21, r.m21);
            report_field("m22", e.m22, r.m22);
            report_field("t0", e.t0, r.t0);
            report_field("t1", e.t1, r.t1);
            report_field("t2", e.t2, r.t2);
        endfunction
    endclass

    localparam int unsigned RANDOM_COUNT = 1230;
    localparam int unsigned STALL_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    q2r_req_if req_ch ();
    q2r_rsp_if rsp_ch ();

    rotation_scoreboard rotations;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    logic        recv_hold;
    int unsigned quiet_cycles;

    quaternion_to_scaled_rotation u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always #4 i_clk = ~i_clk;

    // Random 32-bit word, biased toward the extremes now and then.
    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0;
            default: return $urandom;
        endcase
    endfunction

    // A quaternion vector part: mostly inside the unit ball, some near or past it.
    function automatic t_in_req rand_request();
        t_in_req q;
        int unsigned kind;
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            q.quat_b = $signed($urandom_range(0, 32'h49E6_9D16)) - 32'sh24F3_4E8B;
            q.quat_c = $signed($urandom_range(0, 32'h49E6_9D16)) - 32'sh24F3_4E8B;
            q.quat_d = $signed($urandom_range(0, 32'h49E6_9D16)) - 32'sh24F3_4E8B;
        end else if (kind < 8) begin
            // Pure turn near the boundary where the real part vanishes.
            q.quat_b = $urandom_range(0, 1) ? 32'sh4000_0000 - $urandom_range(0, 64)
                                            : -32'sh4000_0000 + $urandom_range(0, 64);
            q.quat_c = $signed($urandom_range(0, 200)) - 100;
            q.quat_d = $signed($urandom_range(0, 200)) - 100;
        end else begin
            q.quat_b = rand_word();
            q.quat_c = rand_word();
            q.quat_d = rand_word();
        end
        q.spacing_x = ($urandom_range(0, 3) == 0) ? rand_word() : $urandom_range(1, 32'h0010_0000);
        q.spacing_y = ($urandom_range(0, 3) == 0) ? rand_word() : $urandom_range(1, 32'h0010_0000);
        q.spacing_z = ($urandom_range(0, 3) == 0) ? rand_word() : $urandom_range(1, 32'h0010_0000);
        q.left_handed = $urandom_range(0, 1);
        q.shift_x = $urandom;
        q.shift_y = $urandom;
        q.shift_z = $urandom;
        return q;
    endfunction

    function automatic t_in_req make_request(logic signed [31:0] b, logic signed [31:0] c,
                                             logic signed [31:0] d, logic signed [31:0] sp,
                                             logic lh, logic signed [31:0] sh);
        t_in_req q;
        q.quat_b = b; q.quat_c = c; q.quat_d = d;
        q.spacing_x = sp; q.spacing_y = sp; q.spacing_z = sp;
        q.left_handed = lh;
        q.shift_x = sh; q.shift_y = ~sh; q.shift_z = -sh;
        return q;
    endfunction

    // Offer one request and hold it until the block takes it. Valid drops
    // only while the sender idles, so requests can follow back to back.
    task automatic send_request(t_in_req q);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req   <= q;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        rotations.note_request(q);
        @(negedge i_clk);
    endtask

    // Receiver: random backpressure, with one long hold.
    always @(negedge i_clk) begin
        if (!i_rst_n || recv_hold) rsp_ch.ready <= 1'b0;
        else rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Check results and watch for a stuck block.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) rotations.check_result(rsp_ch.rsp);
            if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (!recv_hold) begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("quaternion_to_scaled_rotation test failed");
                $finish;
            end
        end
    end

    // Long receiver hold so the pipeline fills and stalls its input.
    initial begin
        recv_hold = 1'b0;
        @(posedge i_rst_n);
        repeat (200) @(negedge i_clk);
        recv_hold <= 1'b1;
        repeat (300) @(negedge i_clk);
        recv_hold <= 1'b0;
    end

    initial begin
        t_in_req q;
        int unsigned phase_len;
        rotations = new();
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        quiet_cycles = 0;
        req_ch.valid = 1'b0;
        req_ch.req = '0;
        rsp_ch.ready = 1'b0;
        send_idle_pct = 24;
        recv_idle_pct = 72;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners: identity, half turns, boundary of the real part,
        // out-of-range vectors, spacing and handedness extremes, saturation.
        send_request(make_request(0, 0, 0, 32'sh0001_0000, 0, 0));
        send_request(make_request(32'sh4000_0000, 0, 0, 32'sh0002_0000, 0, 32'sh7FFF_FFFF));
        send_request(make_request(0, 32'sh4000_0000, 0, 32'sh0000_8000, 1, 32'sh8000_0000));
        send_request(make_request(0, 0, 32'sh4000_0000, 32'sh0001_0000, 1, -1));
        send_request(make_request(32'sh3FFF_FFFF, 0, 0, 32'sh0001_0000, 0, 1));
        send_request(make_request(32'sh3FFF_FF00, 0, 0, 32'sh0001_0000, 0, 2));
        send_request(make_request(32'sh3FFF_FE00, 100, -100, 32'sh0001_0000, 0, 3));
        send_request(make_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                  32'sh7FFF_FFFF, 0, 4));
        send_request(make_request(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                  32'sh7FFF_FFFF, 1, 5));
        send_request(make_request(32'sh8000_0000, 0, 1, 32'sh8000_0000, 1, 6));
        send_request(make_request(1, 0, 0, 0, 0, 7));
        send_request(make_request(-1, -1, -1, -1, 1, 8));
        send_request(make_request(32'sh2000_0000, 32'sh2000_0000, 32'sh2000_0000,
                                  32'sh7FFF_FFFF, 0, 9));
        send_request(make_request(32'sh2D41_3CCD, 0, -32'sh2D41_3CCD, 32'sh0000_0001, 1, 10));
        send_request(make_request(32'sh2D41_3CCD, 32'sh2D41_3CCD, 0, 32'sh7FFF_FFFF, 1, 11));
        send_request(make_request(-32'sh24F3_4E8B, 32'sh24F3_4E8B, -32'sh24F3_4E8B,
                                  32'sh0100_0000, 0, 12));

        // Random part in three idling phases.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 72 : 0;
            recv_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 24 : 0;
            phase_len = RANDOM_COUNT / 3;
            for (int n = 0; n < phase_len; n++) begin
                q = rand_request();
                send_request(q);
            end
        end
        req_ch.valid <= 1'b0;

        while (rotations.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("covered %0d orientations: unit-ball, vanishing real part, out-of-range",
                 rotations.checked);
        $display("vectors, nonpositive and extreme spacings, both handedness settings");
        if (rotations.mismatches == 0) begin
            $display("quaternion_to_scaled_rotation test passed");
        end else begin
            $display("%0d mismatches", rotations.mismatches);
            $display("quaternion_to_scaled_rotation test failed");
        end
        $finish;
    end
endmodule
